// File: sv/spic_pkg.sv
// ----------------------------------------------------------------------------
// spic_pkg
// shared widths, class codes and pipeline structs for the segment pair test
// ----------------------------------------------------------------------------
package spic_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int N_MUL   = 6;

    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_HIT   = 2'd1;
    localparam logic [1:0] CLASS_CROSS = 2'd2;

    // geometry cases: s = sloped, v = vertical, segment a first
    localparam logic [1:0] CASE_SS = 2'd0;
    localparam logic [1:0] CASE_SV = 2'd1;
    localparam logic [1:0] CASE_VS = 2'd2;
    localparam logic [1:0] CASE_VV = 2'd3;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_diff [N_MUL-1:0] x;
        t_diff [N_MUL-1:0] y;
    } t_ops;

    typedef struct packed {
        logic [1:0] geo;
        logic       live;
        logic       vv_hit;
        logic       apart;
        t_diff      dob;
    } t_ctl;

endpackage

// File: sv/spic_if.sv
// ----------------------------------------------------------------------------
// spic_seg_if / spic_cls_if
// valid/ready channels for segment pairs in and contact classes out
// ----------------------------------------------------------------------------
interface spic_seg_if;
    logic                         valid;
    logic                         ready;
    logic [spic_pkg::COORD_W-1:0] a_lat_start;
    logic [spic_pkg::COORD_W-1:0] a_lon_start;
    logic [spic_pkg::COORD_W-1:0] a_lat_end;
    logic [spic_pkg::COORD_W-1:0] a_lon_end;
    logic [spic_pkg::COORD_W-1:0] b_lat_start;
    logic [spic_pkg::COORD_W-1:0] b_lon_start;
    logic [spic_pkg::COORD_W-1:0] b_lat_end;
    logic [spic_pkg::COORD_W-1:0] b_lon_end;

    modport source (output valid, a_lat_start, a_lon_start, a_lat_end, a_lon_end,
                    b_lat_start, b_lon_start, b_lat_end, b_lon_end, input ready);
    modport sink   (input valid, a_lat_start, a_lon_start, a_lat_end, a_lon_end,
                    b_lat_start, b_lon_start, b_lat_end, b_lon_end, output ready);
endinterface

interface spic_cls_if;
    logic       valid;
    logic       ready;
    logic [1:0] contact_class;

    modport source (output valid, contact_class, input ready);
    modport sink   (input valid, contact_class, output ready);
endinterface

// File: sv/segment_pair_intersection_class.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection_class
// classifies a pair of integer line segments as apart, touching or crossing
// ----------------------------------------------------------------------------
// Four register stages: operand set-up, six 33x33 signed multiplies, the three
// cross-product differences, then the sign tests into the output register.
// One pair is taken every cycle while the output side does not stall; each result
// passes through the operand, product, difference and class registers in turn. Each
// stage holds its word while the next one is full, so bubbles close up under
// back-pressure.
module segment_pair_intersection_class (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spic_seg_if.sink           i_seg,
    spic_cls_if.source         o_cls
);
    spic_pkg::t_ops ops;
    spic_pkg::t_ctl ctl;

    logic r_v1, r_v2, r_v3, r_v4;
    logic e1, e2, e3, e4;

    spic_pkg::t_ops                  r_ops;
    spic_pkg::t_ctl                  r_ctl1, r_ctl2, r_ctl3;
    spic_pkg::t_prod [spic_pkg::N_MUL-1:0] r_prod, n_prod;
    spic_pkg::t_sum                  r_det, r_m, r_l, n_det, n_m, n_l;
    logic [1:0]                      r_cls, n_cls;

    spic_pkg::t_sum neg_dob, pos_dob;
    logic           cross_ss, side_cross;

    spic_prep u_prep (
        .i_a_lat_start (i_seg.a_lat_start),
        .i_a_lon_start (i_seg.a_lon_start),
        .i_a_lat_end   (i_seg.a_lat_end),
        .i_a_lon_end   (i_seg.a_lon_end),
        .i_b_lat_start (i_seg.b_lat_start),
        .i_b_lon_start (i_seg.b_lon_start),
        .i_b_lat_end   (i_seg.b_lat_end),
        .i_b_lon_end   (i_seg.b_lon_end),
        .o_ops         (ops),
        .o_ctl         (ctl)
    );

    // each stage may load when empty or when its word moves on
    assign e4 = !r_v4 || o_cls.ready;
    assign e3 = !r_v3 || e4;
    assign e2 = !r_v2 || e3;
    assign e1 = !r_v1 || e2;

    assign i_seg.ready         = e1;
    assign o_cls.valid         = r_v4;
    assign o_cls.contact_class = r_cls;

    always_comb begin
        for (int k = 0; k < spic_pkg::N_MUL; k++) begin
            n_prod[k] = $signed(r_ops.x[k]) * $signed(r_ops.y[k]);
        end
        n_det = spic_pkg::t_sum'(r_prod[0]) - spic_pkg::t_sum'(r_prod[1]);
        n_m   = spic_pkg::t_sum'(r_prod[2]) - spic_pkg::t_sum'(r_prod[3]);
        n_l   = spic_pkg::t_sum'(r_prod[4]) - spic_pkg::t_sum'(r_prod[5]);
    end

    always_comb begin
        pos_dob = spic_pkg::t_sum'(r_ctl3.dob);
        neg_dob = -pos_dob;
        // crossing point strictly inside a, inside b ends included
        if (r_det > 0) begin
            cross_ss = (r_m > 0) && (r_m < r_det) && (r_l >= 0) && (r_l <= r_det);
        end else begin
            cross_ss = (r_m < 0) && (r_m > r_det) && (r_l <= 0) && (r_l >= r_det);
        end
        side_cross = ((r_l < 0) && (r_m > 0)) || ((r_m < 0) && (r_l > 0));

        n_cls = spic_pkg::CLASS_NONE;
        case (r_ctl3.geo)
            spic_pkg::CASE_SS: begin
                if (r_det == 0) begin
                    if ((r_m >= neg_dob) && (r_m <= pos_dob)) n_cls = spic_pkg::CLASS_HIT;
                end else if (cross_ss && r_ctl3.apart) begin
                    n_cls = spic_pkg::CLASS_CROSS;
                end
            end
            spic_pkg::CASE_SV, spic_pkg::CASE_VS: begin
                if (side_cross) n_cls = spic_pkg::CLASS_CROSS;
            end
            spic_pkg::CASE_VV: begin
                if (r_ctl3.vv_hit) n_cls = spic_pkg::CLASS_HIT;
            end
            default: n_cls = spic_pkg::CLASS_NONE;
        endcase
        if (!r_ctl3.live) n_cls = spic_pkg::CLASS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_seg.valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r_ops  <= ops;
            r_ctl1 <= ctl;
        end
        if (e2) begin
            r_prod <= n_prod;
            r_ctl2 <= r_ctl1;
        end
        if (e3) begin
            r_det  <= n_det;
            r_m    <= n_m;
            r_l    <= n_l;
            r_ctl3 <= r_ctl2;
        end
        if (e4) begin
            r_cls <= n_cls;
        end
    end

    a_cls_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cls.valid |-> (o_cls.contact_class == spic_pkg::CLASS_NONE ||
                         o_cls.contact_class == spic_pkg::CLASS_HIT ||
                         o_cls.contact_class == spic_pkg::CLASS_CROSS))
        else $error("contact class code out of range");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_seg.ready)
        else $error("input held off with first stage empty");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !e4) |=> (r_v3 && $stable(r_det) && $stable(r_m) && $stable(r_l)))
        else $error("difference stage word lost under stall");

endmodule

// File: sv/spic_prep.sv
// ----------------------------------------------------------------------------
// spic_prep
// orders both segments, picks the geometry case and steers multiplier operands
// ----------------------------------------------------------------------------
module spic_prep (
    input  logic [spic_pkg::COORD_W-1:0] i_a_lat_start,
    input  logic [spic_pkg::COORD_W-1:0] i_a_lon_start,
    input  logic [spic_pkg::COORD_W-1:0] i_a_lat_end,
    input  logic [spic_pkg::COORD_W-1:0] i_a_lon_end,
    input  logic [spic_pkg::COORD_W-1:0] i_b_lat_start,
    input  logic [spic_pkg::COORD_W-1:0] i_b_lon_start,
    input  logic [spic_pkg::COORD_W-1:0] i_b_lat_end,
    input  logic [spic_pkg::COORD_W-1:0] i_b_lon_end,
    output spic_pkg::t_ops               o_ops,
    output spic_pkg::t_ctl               o_ctl
);
    logic                         a_rev, a_vert, b_rev, b_vert;
    logic [spic_pkg::COORD_W-1:0] la0, oa0, la1, oa1, lb0, ob0, lb1, ob1;
    logic [spic_pkg::COORD_W-1:0] alo, ahi, blo, bhi;
    spic_pkg::t_diff              dla, doa, dlb, dob, e_l, e_o, f_l, g0, g1, h;

    always_comb begin
        a_rev  = i_a_lon_end < i_a_lon_start;
        a_vert = i_a_lon_end == i_a_lon_start;
        b_rev  = i_b_lon_end < i_b_lon_start;
        b_vert = i_b_lon_end == i_b_lon_start;

        la0 = a_rev ? i_a_lat_end   : i_a_lat_start;
        oa0 = a_rev ? i_a_lon_end   : i_a_lon_start;
        la1 = a_rev ? i_a_lat_start : i_a_lat_end;
        oa1 = a_rev ? i_a_lon_start : i_a_lon_end;
        lb0 = b_rev ? i_b_lat_end   : i_b_lat_start;
        ob0 = b_rev ? i_b_lon_end   : i_b_lon_start;
        lb1 = b_rev ? i_b_lat_start : i_b_lat_end;
        ob1 = b_rev ? i_b_lon_start : i_b_lon_end;

        dla = $signed({1'b0, la1}) - $signed({1'b0, la0});
        doa = $signed({1'b0, oa1}) - $signed({1'b0, oa0});
        dlb = $signed({1'b0, lb1}) - $signed({1'b0, lb0});
        dob = $signed({1'b0, ob1}) - $signed({1'b0, ob0});
        e_l = $signed({1'b0, lb0}) - $signed({1'b0, la0});
        e_o = $signed({1'b0, ob0}) - $signed({1'b0, oa0});
        f_l = $signed({1'b0, lb1}) - $signed({1'b0, la0});
        g0  = $signed({1'b0, la0}) - $signed({1'b0, lb0});
        g1  = $signed({1'b0, la1}) - $signed({1'b0, lb0});
        h   = $signed({1'b0, oa0}) - $signed({1'b0, ob0});

        // latitude ranges of two verticals, order of ends does not matter
        alo = (la0 < la1) ? la0 : la1;
        ahi = (la0 < la1) ? la1 : la0;
        blo = (lb0 < lb1) ? lb0 : lb1;
        bhi = (lb0 < lb1) ? lb1 : lb0;

        o_ctl.dob    = dob;
        o_ctl.apart  = ((la0 != lb0) || (oa0 != ob0)) && ((la1 != lb1) || (oa1 != ob1));
        o_ctl.vv_hit = (oa0 == ob0) && (alo < bhi) && (blo < ahi);

        // slots 0,1 give the determinant, 2..5 the two side tests
        o_ops.x[0] = dla; o_ops.y[0] = dob;
        o_ops.x[1] = dlb; o_ops.y[1] = doa;
        o_ops.x[2] = e_l; o_ops.y[2] = dob;
        o_ops.x[3] = e_o; o_ops.y[3] = dlb;
        o_ops.x[4] = e_l; o_ops.y[4] = doa;
        o_ops.x[5] = e_o; o_ops.y[5] = dla;

        if (a_vert && b_vert) begin
            o_ctl.geo  = spic_pkg::CASE_VV;
            o_ctl.live = 1'b1;
        end else if (a_vert) begin
            o_ctl.geo  = spic_pkg::CASE_VS;
            o_ctl.live = (ob0 < oa0) && (oa0 < ob1);
            o_ops.x[2] = g1; o_ops.y[2] = dob;
            o_ops.x[3] = h;  o_ops.y[3] = dlb;
            o_ops.x[4] = g0; o_ops.y[4] = dob;
            o_ops.x[5] = h;  o_ops.y[5] = dlb;
        end else if (b_vert) begin
            o_ctl.geo  = spic_pkg::CASE_SV;
            o_ctl.live = (oa0 < ob0) && (ob0 < oa1);
            o_ops.x[2] = f_l; o_ops.y[2] = doa;
            o_ops.x[3] = e_o; o_ops.y[3] = dla;
        end else begin
            o_ctl.geo  = spic_pkg::CASE_SS;
            o_ctl.live = (oa0 < ob1) && (ob0 < oa1);
        end
    end
endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the segment pair classifier against an exact integer predictor, with
// directed corner pairs, random and near-degenerate pairs, and random stalls
// ----------------------------------------------------------------------------
module tb;

    typedef logic signed [67:0] t_wide;

    typedef struct {
        logic [spic_pkg::COORD_W-1:0] c [8];
    } t_pair;

    // expected classes, oldest first
    class contact_board;
        logic [1:0] pending [$];
        int         errors;

        function t_wide sx(logic [spic_pkg::COORD_W-1:0] v);
            return $signed({36'd0, v});
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // sign of (v - lat0) * dlo - (q - lon0) * dl
        function int side(t_wide lat0, t_wide lon0, t_wide dl, t_wide dlo,
                          t_wide q, t_wide v);
            t_wide r;
            r = (v - lat0) * dlo - (q - lon0) * dl;
            return (r < 0) ? -1 : ((r > 0) ? 1 : 0);
        endfunction

        function logic [1:0] both_sloped(t_wide la0, t_wide oa0, t_wide la1,
                t_wide oa1, t_wide lb0, t_wide ob0, t_wide lb1, t_wide ob1);
            t_wide dla, doa, dlb, dob, det, m, l;
            dla = la1 - la0; doa = oa1 - oa0; dlb = lb1 - lb0; dob = ob1 - ob0;
            det = dla * dob - dlb * doa;
            m = (lb0 - la0) * dob - (ob0 - oa0) * dlb;
            if (det != 0) begin
                l = (lb0 - la0) * doa - (ob0 - oa0) * dla;
                if (det < 0) begin
                    det = -det; m = -m; l = -l;
                end
                if (m > 0 && det - m > 0 && l >= 0 && det - l >= 0) begin
                    if ((la0 != lb0 || oa0 != ob0) && (la1 != lb1 || oa1 != ob1))
                        return spic_pkg::CLASS_CROSS;
                end
                return spic_pkg::CLASS_NONE;
            end
            if (m < 0) m = -m;
            return (dob - m >= 0) ? spic_pkg::CLASS_HIT : spic_pkg::CLASS_NONE;
        endfunction

        function logic [1:0] sloped_a(t_wide la0, t_wide oa0, t_wide la1,
                t_wide oa1, t_wide lb0, t_wide ob0, t_wide lb1, t_wide ob1);
            int s0, s1;
            if (ob0 < ob1) begin
                if (oa0 < ob1 && ob0 < oa1)
                    return both_sloped(la0, oa0, la1, oa1, lb0, ob0, lb1, ob1);
            end else if (ob1 < ob0) begin
                if (oa0 < ob0 && ob1 < oa1)
                    return both_sloped(la0, oa0, la1, oa1, lb1, ob1, lb0, ob0);
            end else if (oa0 < ob0 && ob0 < oa1) begin
                s0 = side(la0, oa0, la1 - la0, oa1 - oa0, ob0, lb0);
                s1 = side(la0, oa0, la1 - la0, oa1 - oa0, ob0, lb1);
                return ((s0 < 0 && s1 > 0) || (s1 < 0 && s0 > 0)) ? spic_pkg::CLASS_CROSS
                                                                  : spic_pkg::CLASS_NONE;
            end
            return spic_pkg::CLASS_NONE;
        endfunction

        function logic [1:0] vertical_a(t_wide la0, t_wide oa, t_wide la1,
                t_wide lb0, t_wide ob0, t_wide lb1, t_wide ob1);
            t_wide t;
            int s0, s1;
            if (ob0 != ob1) begin
                if (ob1 < ob0) begin
                    t = lb0; lb0 = lb1; lb1 = t;
                    t = ob0; ob0 = ob1; ob1 = t;
                end
                if (!(ob0 < oa && oa < ob1)) return spic_pkg::CLASS_NONE;
                s0 = side(lb0, ob0, lb1 - lb0, ob1 - ob0, oa, la0);
                s1 = side(lb0, ob0, lb1 - lb0, ob1 - ob0, oa, la1);
                return ((s0 < 0 && s1 > 0) || (s1 < 0 && s0 > 0)) ? spic_pkg::CLASS_CROSS
                                                                  : spic_pkg::CLASS_NONE;
            end
            if (oa != ob0) return spic_pkg::CLASS_NONE;
            if (la0 < la1) begin
                if (lb0 < lb1)
                    return (la0 < lb1 && lb0 < la1) ? spic_pkg::CLASS_HIT : spic_pkg::CLASS_NONE;
                return (la0 < lb0 && lb1 < la1) ? spic_pkg::CLASS_HIT : spic_pkg::CLASS_NONE;
            end
            if (lb0 < lb1)
                return (la1 < lb1 && lb0 < la0) ? spic_pkg::CLASS_HIT : spic_pkg::CLASS_NONE;
            return (la1 < lb0 && lb1 < la0) ? spic_pkg::CLASS_HIT : spic_pkg::CLASS_NONE;
        endfunction

        function void note_pair(t_pair p);
            t_wide v [8];
            logic [1:0] cls;
            for (int i = 0; i < 8; i++) v[i] = sx(p.c[i]);
            if (v[1] < v[3])
                cls = sloped_a(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
            else if (v[3] < v[1])
                cls = sloped_a(v[2], v[3], v[0], v[1], v[4], v[5], v[6], v[7]);
            else
                cls = vertical_a(v[0], v[1], v[2], v[4], v[5], v[6], v[7]);
            pending.insert(pending.size(), cls);
        endfunction

        task check_class(logic [1:0] got);
            logic [1:0] want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("class %0d with nothing pending", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report_mismatch($sformatf("contact_class got %0d want %0d", got, want));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles;
    contact_board board;

    spic_seg_if seg ();
    spic_cls_if cls ();

    segment_pair_intersection_class i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg.sink),
        .o_cls   (cls.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // output stalls, with calm stretches
    int ready_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cls.ready <= 1'b0;
            ready_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) ready_mode <= $urandom_range(0, 2);
            case (ready_mode)
                0: cls.ready <= 1'b1;
                1: cls.ready <= ($urandom_range(0, 3) != 0);
                default: cls.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && cls.valid && cls.ready) begin
            board.check_class(cls.contact_class);
        end
    end

    task automatic send_pair(t_pair p);
        int g;
        g = gap_len();
        repeat (g) begin
            seg.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg.valid       <= 1'b1;
        seg.a_lat_start <= p.c[0];
        seg.a_lon_start <= p.c[1];
        seg.a_lat_end   <= p.c[2];
        seg.a_lon_end   <= p.c[3];
        seg.b_lat_start <= p.c[4];
        seg.b_lon_start <= p.c[5];
        seg.b_lat_end   <= p.c[6];
        seg.b_lon_end   <= p.c[7];
        @(posedge i_clk);
        while (!seg.ready) @(posedge i_clk);
        board.note_pair(p);
    endtask

    function automatic t_pair build_pair(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
            logic [31:0] a3, logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
            logic [31:0] b3);
        t_pair p;
        p.c[0] = a0; p.c[1] = a1; p.c[2] = a2; p.c[3] = a3;
        p.c[4] = b0; p.c[5] = b1; p.c[6] = b2; p.c[7] = b3;
        return p;
    endfunction

    // coordinates mostly clustered in a small window so that shapes meet often
    function automatic t_pair random_pair();
        t_pair p;
        logic [31:0] base_lat, base_lon;
        int span, kind;
        kind = $urandom_range(0, 9);
        base_lat = $urandom;
        base_lon = $urandom;
        span = (kind < 4) ? 8 : ((kind < 8) ? 1000 : 0);
        for (int i = 0; i < 8; i++) begin
            if (span == 0) p.c[i] = $urandom;
            else if (i % 2 == 0) p.c[i] = base_lat + $urandom_range(0, span);
            else p.c[i] = base_lon + $urandom_range(0, span);
        end
        case ($urandom_range(0, 7))
            0: p.c[3] = p.c[1];                          // vertical a
            1: p.c[7] = p.c[5];                          // vertical b
            2: begin p.c[3] = p.c[1]; p.c[5] = p.c[1]; p.c[7] = p.c[1]; end
            3: begin p.c[4] = p.c[0]; p.c[5] = p.c[1]; end  // shared start
            4: begin                                     // parallel, offset
                p.c[4] = p.c[0] + $urandom_range(0, 2) - 1;
                p.c[5] = p.c[1];
                p.c[6] = p.c[2] + p.c[4] - p.c[0];
                p.c[7] = p.c[3];
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        logic [31:0] mx;
        int wait_cnt;
        board = new();
        cycles = 0;
        mx = 32'hFFFF_FFFF;
        i_rst_n = 1'b0;
        seg.valid <= 1'b0;
        {seg.a_lat_start, seg.a_lon_start, seg.a_lat_end, seg.a_lon_end} <= '0;
        {seg.b_lat_start, seg.b_lon_start, seg.b_lat_end, seg.b_lon_end} <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // proper crossing, an x shape
        send_pair(build_pair(0, 0, 10, 10, 10, 0, 0, 10));
        // same crossing at the top of the range
        send_pair(build_pair(mx - 10, mx - 10, mx, mx, mx, mx - 10, mx - 10, mx));
        // widest crossing over the whole range
        send_pair(build_pair(0, 0, mx, mx, mx, 0, 0, mx));
        // a reversed, crossing
        send_pair(build_pair(10, 10, 0, 0, 10, 0, 0, 10));
        // shared start endpoint
        send_pair(build_pair(0, 0, 10, 10, 0, 0, 10, 5));
        // parallel within one unit
        send_pair(build_pair(0, 0, 10, 10, 1, 0, 11, 10));
        // parallel two units apart
        send_pair(build_pair(0, 0, 10, 10, 2, 0, 12, 10));
        // longitude ranges only touching
        send_pair(build_pair(0, 0, 10, 10, 10, 10, 0, 20));
        // vertical b crossing sloped a
        send_pair(build_pair(0, 0, 10, 10, 0, 5, 10, 5));
        // vertical b ending on a
        send_pair(build_pair(0, 0, 10, 10, 5, 5, 10, 5));
        // vertical a crossed by sloped b
        send_pair(build_pair(0, 5, 10, 5, 10, 0, 0, 10));
        // vertical a, b reversed
        send_pair(build_pair(10, 5, 0, 5, 0, 10, 10, 0));
        // vertical a and b, different longitude
        send_pair(build_pair(0, 5, 10, 5, 0, 6, 10, 6));
        // both vertical, overlapping
        send_pair(build_pair(0, 5, 10, 5, 5, 5, 15, 5));
        send_pair(build_pair(10, 5, 0, 5, 15, 5, 5, 5));
        // both vertical, only touching
        send_pair(build_pair(0, 5, 10, 5, 10, 5, 20, 5));
        // degenerate a, both points
        send_pair(build_pair(5, 5, 5, 5, 0, 5, 10, 5));
        send_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(build_pair(mx, mx, mx, mx, mx, mx, mx, mx));
        // far apart
        send_pair(build_pair(0, 0, 10, 10, mx, mx, mx - 5, mx - 9));
        // vertical a at longitude one crossed at full span
        send_pair(build_pair(0, 1, mx, 1, mx, 0, 0, 2));

        for (int n = 0; n < 1600; n++) send_pair(random_pair());
        seg.valid <= 1'b0;

        wait_cnt = 0;
        while (board.pending.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (10) @(posedge i_clk);
        if (board.pending.size() != 0)
            board.report_mismatch($sformatf("%0d classes never arrived",
                                            board.pending.size()));
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("status: fail");
        $finish;
    end
endmodule

// File: sim.f
sv/spic_pkg.sv
sv/spic_if.sv
sv/spic_prep.sv
sv/segment_pair_intersection_class.sv
sim/tb.sv
